FILE: hdl/idl_pkg.sv
// ----------------------------------------------------------------------------
// idl_pkg
// Shared types, constants and table of the interferometer DOA likelihood block.
// ----------------------------------------------------------------------------
package idl_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SUM_WIDTH    = 48;
  localparam int DIMENSIONS   = 3;

  localparam int PAIRS   = MAX_CHANNELS * (MAX_CHANNELS - 1) / 2;
  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int PAIR_W  = $clog2(PAIRS);
  localparam int USED_W  = $clog2(MAX_CHANNELS + 1);
  localparam int COORD_W = 16;
  localparam int POS_W   = DIMENSIONS * COORD_W;
  localparam int DIM_W   = $clog2(DIMENSIONS);
  localparam int SH_W    = $clog2(SUM_WIDTH);
  localparam int DOT_W   = 52;
  localparam int NUM_W   = 34 + PAIR_W;
  localparam int DEN_W   = 33 + PAIR_W;
  localparam int DIVN_W  = NUM_W + 15;
  localparam int DIVC_W  = $clog2(DIVN_W);

  localparam int          CORDIC_STEPS = 16;
  localparam logic [33:0] CORDIC_K_Q30 = 34'd652032874;
  localparam logic [15:0] LH_ONE       = 16'd16384;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_LOAD_POS = 2'd1,
    CMD_LOAD_SMP = 2'd2,
    CMD_EVALUATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_ACTIVE_CHANNELS = 2'd0,
    CFG_WINDOW_FIRST    = 2'd1,
    CFG_WINDOW_LAST     = 2'd2,
    CFG_WAVE_NUMBER     = 2'd3
  } cfg_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         channel;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] samp_re;
    logic signed [15:0] samp_im;
    logic [15:0]        azimuth;
    logic signed [15:0] elevation;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] likelihood;
    logic               no_signal;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic pos_wr;
    logic smp_wr;
    logic pair_rst;
    logic pair_next;
    logic cm_mul;
    logic cm_acc;
    logic idx_bump;
    logic ev_init;
    logic cord_az;
    logic cord_el;
    logic cord_ph;
    logic cap_az;
    logic cap_el;
    logic cap_ph;
    logic dir0;
    logic dir1;
    logic max_step;
    logic sh_step;
    logic ev_load;
    logic dot_step;
    logic phase;
    logic n0;
    logic n1;
    logic n2;
    logic m0;
    logic m1;
    logic sq_load;
    logic sq_step;
    logic den_add;
    logic div_load;
    logic div_step;
    logic res_write;
  } idl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic commit_go;
    logic in_window;
    logic pair_used;
    logic pair_last;
    logic cord_done;
    logic sh_done;
    logic dot_done;
    logic sq_done;
    logic den_zero;
    logic div_done;
    logic out_free;
  } idl_stat_t;

  // arctangent of 2^-k, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd0:    r = 32'd536870912;
      4'd1:    r = 32'd316933406;
      4'd2:    r = 32'd167458907;
      4'd3:    r = 32'd85004756;
      4'd4:    r = 32'd42667331;
      4'd5:    r = 32'd21354465;
      4'd6:    r = 32'd10679838;
      4'd7:    r = 32'd5340245;
      4'd8:    r = 32'd2670163;
      4'd9:    r = 32'd1335087;
      4'd10:   r = 32'd667544;
      4'd11:   r = 32'd333772;
      4'd12:   r = 32'd166886;
      4'd13:   r = 32'd83443;
      4'd14:   r = 32'd41722;
      4'd15:   r = 32'd20861;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/idl_ram.sv
// ----------------------------------------------------------------------------
// idl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module idl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/idl_cordic.sv
// ----------------------------------------------------------------------------
// idl_cordic
// Iterative rotation CORDIC: angle in 2^32 per turn, cos and sin in Q30.
// ----------------------------------------------------------------------------
module idl_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import idl_pkg::*;

  logic signed [33:0] x_q, y_q, z_q;
  logic signed [33:0] x_d, y_d, z_d, dx, dy, at;
  logic [3:0]         k_q;
  logic               busy_q, flip_q, done_q;
  logic signed [31:0] cos_q, sin_q;
  logic [31:0]        rot, ang;

  always_comb begin
    rot = angle_i + 32'h4000_0000;
    ang = rot[31] ? angle_i + 32'h8000_0000 : angle_i;
    dx  = y_q >>> k_q;
    dy  = x_q >>> k_q;
    at  = 34'(atan_turn(k_q));
    if (!z_q[33]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - at;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && k_q == 4'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flip_q <= rot[31];
      x_q    <= CORDIC_K_Q30;
      y_q    <= '0;
      z_q    <= {{2{ang[31]}}, ang};
      k_q    <= '0;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      k_q <= k_q + 4'd1;
      if (k_q == 4'(CORDIC_STEPS - 1)) begin
        cos_q <= flip_q ? 32'(-x_d) : 32'(x_d);
        sin_q <= flip_q ? 32'(-y_d) : 32'(y_d);
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

FILE: hdl/idl_datapath.sv
// ----------------------------------------------------------------------------
// idl_datapath
// Registers, storage and arithmetic for snapshot accumulation and evaluation.
// ----------------------------------------------------------------------------
module idl_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  idl_pkg::in_item_t   in_item_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                out_ready_i,
  output idl_pkg::out_item_t  out_item_o,
  output logic                out_valid_o,
  input  idl_pkg::idl_cmd_t   cmd_i,
  output idl_pkg::idl_stat_t  stat_o
);
  import idl_pkg::*;

  in_item_t item_q;
  logic [3:0]  active_q;
  logic [15:0] first_q, last_q, idx_q;
  logic [31:0] wave_q;

  logic signed [SUM_WIDTH-1:0] sum_re_q [PAIRS];
  logic signed [SUM_WIDTH-1:0] sum_im_q [PAIRS];

  logic [CH_W-1:0]   lo_q, hi_q;
  logic [PAIR_W-1:0] p_q;
  logic [USED_W-1:0] used;
  logic              pair_last;

  logic [POS_W-1:0] pos_lo, pos_hi;
  logic [31:0]      smp_lo, smp_hi;
  logic             ch_ok;

  // commit
  logic signed [31:0] pr_rr_q, pr_ii_q, pr_ir_q, pr_ri_q;
  logic signed [32:0] add_re, add_im;
  logic signed [SUM_WIDTH:0] sat_re, sat_im;

  // evaluate
  logic signed [31:0] ca_q, sa_q, ce_q, se_q, dir0_q, dir1_q, cv_q, sv_q;
  logic signed [63:0] dprod;
  logic [SUM_WIDTH-1:0] big_q, abs_re, abs_im, big_sh;
  logic [SH_W-1:0]      sh_q;
  logic signed [SUM_WIDTH-1:0] cur_re, cur_im, sh_re, sh_im;
  logic signed [31:0]   re_q, im_q;
  logic [DIM_W-1:0]     dim_q;
  logic signed [COORD_W:0] dpos;
  logic signed [31:0]   dir_k;
  logic signed [DOT_W-1:0] dot_q, dot_sh;
  logic signed [27:0]   dot28;
  logic signed [60:0]   ph_prod;
  logic [31:0]          phase_q, cord_angle;
  logic signed [63:0]   t0_q, t1_q;
  logic signed [64:0]   tsum, tsh;
  logic signed [NUM_W-1:0] num_q;
  logic [63:0]          m0_q, m1_q, sq_v_q, sq_root_q, sq_bit_q, sq_trial;
  logic [DEN_W-1:0]     den_q, rem_q;
  logic [DEN_W:0]       div_trial;
  logic [DIVN_W-1:0]    nq_q;
  logic [DIVC_W-1:0]    div_cnt_q;
  logic [NUM_W-1:0]     num_abs;
  logic                 num_pos;
  logic [14:0]          q_clamp;
  logic [15:0]          q_mag;
  out_item_t            out_q;
  logic                 out_valid_q, cord_done;
  logic signed [31:0]   cord_cos, cord_sin;

  // ---------------- storage ----------------
  assign ch_ok = int'(item_q.channel) < MAX_CHANNELS;

  idl_ram #(.WIDTH(POS_W), .DEPTH(MAX_CHANNELS)) u_pos_lo (
    .clk_i, .we_i(cmd_i.pos_wr && ch_ok), .waddr_i(CH_W'(item_q.channel)),
    .wdata_i({item_q.pos_x, item_q.pos_y, item_q.pos_z}),
    .raddr_i(lo_q), .rdata_o(pos_lo));
  idl_ram #(.WIDTH(POS_W), .DEPTH(MAX_CHANNELS)) u_pos_hi (
    .clk_i, .we_i(cmd_i.pos_wr && ch_ok), .waddr_i(CH_W'(item_q.channel)),
    .wdata_i({item_q.pos_x, item_q.pos_y, item_q.pos_z}),
    .raddr_i(hi_q), .rdata_o(pos_hi));
  idl_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_smp_lo (
    .clk_i, .we_i(cmd_i.smp_wr && ch_ok), .waddr_i(CH_W'(item_q.channel)),
    .wdata_i({item_q.samp_re, item_q.samp_im}),
    .raddr_i(lo_q), .rdata_o(smp_lo));
  idl_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_smp_hi (
    .clk_i, .we_i(cmd_i.smp_wr && ch_ok), .waddr_i(CH_W'(item_q.channel)),
    .wdata_i({item_q.samp_re, item_q.samp_im}),
    .raddr_i(hi_q), .rdata_o(smp_hi));

  // ---------------- shared CORDIC ----------------
  always_comb begin
    if (cmd_i.cord_az) begin
      cord_angle = {item_q.azimuth, 16'h0000};
    end else if (cmd_i.cord_el) begin
      cord_angle = {item_q.elevation, 16'h0000};
    end else begin
      cord_angle = phase_q;
    end
  end

  idl_cordic u_cordic (
    .clk_i, .rst_ni,
    .start_i(cmd_i.cord_az || cmd_i.cord_el || cmd_i.cord_ph),
    .angle_i(cord_angle), .done_o(cord_done), .cos_o(cord_cos), .sin_o(cord_sin));

  // ---------------- combinational helpers ----------------
  always_comb begin
    if ({1'b0, active_q} > 5'(MAX_CHANNELS)) begin
      used = USED_W'(MAX_CHANNELS);
    end else begin
      used = USED_W'(active_q);
    end
    pair_last = (lo_q == CH_W'(MAX_CHANNELS - 2)) && (hi_q == CH_W'(MAX_CHANNELS - 1));

    add_re = 33'(pr_rr_q) + 33'(pr_ii_q);
    add_im = 33'(pr_ir_q) - 33'(pr_ri_q);
    sat_re = (SUM_WIDTH + 1)'(sum_re_q[p_q]) + (SUM_WIDTH + 1)'(add_re);
    sat_im = (SUM_WIDTH + 1)'(sum_im_q[p_q]) + (SUM_WIDTH + 1)'(add_im);

    cur_re = sum_re_q[p_q];
    cur_im = sum_im_q[p_q];
    abs_re = cur_re[SUM_WIDTH-1] ? SUM_WIDTH'(-cur_re) : SUM_WIDTH'(cur_re);
    abs_im = cur_im[SUM_WIDTH-1] ? SUM_WIDTH'(-cur_im) : SUM_WIDTH'(cur_im);
    big_sh = big_q >> sh_q;
    sh_re  = cur_re >>> sh_q;
    sh_im  = cur_im >>> sh_q;

    case (dim_q)
      DIM_W'(0): dir_k = dir0_q;
      DIM_W'(1): dir_k = dir1_q;
      default:   dir_k = se_q;
    endcase
    dpos = (COORD_W + 1)'($signed(pos_hi[(POS_W - COORD_W) - COORD_W * int'(dim_q) +: COORD_W]))
         - (COORD_W + 1)'($signed(pos_lo[(POS_W - COORD_W) - COORD_W * int'(dim_q) +: COORD_W]));
    dprod  = 64'(dpos) * 64'(dir_k);
    dot_sh = dot_q >>> 24;
    dot28  = dot_sh[27:0];
    ph_prod = 61'($signed({1'b0, wave_q})) * 61'(dot28);

    tsum = 65'(t0_q) + 65'(t1_q);
    tsh  = tsum >>> 30;

    sq_trial  = sq_root_q + sq_bit_q;
    div_trial = {rem_q, nq_q[DIVN_W-1]};

    num_abs = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
    num_pos = !num_q[NUM_W-1] && (num_q != '0);
    q_clamp = (nq_q > DIVN_W'(LH_ONE)) ? LH_ONE[14:0] : nq_q[14:0];
    q_mag   = {1'b0, q_clamp};
  end

  // ---------------- control-like registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 4'd8;
      first_q     <= 16'd0;
      last_q      <= 16'hFFFF;
      wave_q      <= 32'd65536;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= CH_W'(1);
      p_q         <= '0;
      for (int i = 0; i < PAIRS; i++) begin
        sum_re_q[i] <= '0;
        sum_im_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_addr_i))
          CFG_ACTIVE_CHANNELS: active_q <= cfg_wdata_i[3:0];
          CFG_WINDOW_FIRST:    first_q  <= cfg_wdata_i[15:0];
          CFG_WINDOW_LAST:     last_q   <= cfg_wdata_i[15:0];
          CFG_WAVE_NUMBER:     wave_q   <= cfg_wdata_i;
          default:             ;
        endcase
      end
      if (cmd_i.clear) begin
        idx_q <= '0;
        for (int i = 0; i < PAIRS; i++) begin
          sum_re_q[i] <= '0;
          sum_im_q[i] <= '0;
        end
      end
      if (cmd_i.idx_bump && idx_q != 16'hFFFF) begin
        idx_q <= idx_q + 16'd1;
      end
      if (cmd_i.cm_acc) begin
        if (sat_re[SUM_WIDTH] != sat_re[SUM_WIDTH-1]) begin
          sum_re_q[p_q] <= {sat_re[SUM_WIDTH], {(SUM_WIDTH - 1){!sat_re[SUM_WIDTH]}}};
        end else begin
          sum_re_q[p_q] <= sat_re[SUM_WIDTH-1:0];
        end
        if (sat_im[SUM_WIDTH] != sat_im[SUM_WIDTH-1]) begin
          sum_im_q[p_q] <= {sat_im[SUM_WIDTH], {(SUM_WIDTH - 1){!sat_im[SUM_WIDTH]}}};
        end else begin
          sum_im_q[p_q] <= sat_im[SUM_WIDTH-1:0];
        end
      end
      if (cmd_i.pair_rst) begin
        lo_q <= '0;
        hi_q <= CH_W'(1);
        p_q  <= '0;
      end else if (cmd_i.pair_next) begin
        p_q <= p_q + PAIR_W'(1);
        if (hi_q == CH_W'(MAX_CHANNELS - 1)) begin
          lo_q <= lo_q + CH_W'(1);
          hi_q <= lo_q + CH_W'(2);
        end else begin
          hi_q <= hi_q + CH_W'(1);
        end
      end
      if (cmd_i.res_write) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_item_i;
    if (cmd_i.cm_mul) begin
      pr_rr_q <= 32'($signed(smp_hi[31:16])) * 32'($signed(smp_lo[31:16]));
      pr_ii_q <= 32'($signed(smp_hi[15:0])) * 32'($signed(smp_lo[15:0]));
      pr_ir_q <= 32'($signed(smp_hi[15:0])) * 32'($signed(smp_lo[31:16]));
      pr_ri_q <= 32'($signed(smp_hi[31:16])) * 32'($signed(smp_lo[15:0]));
    end
    if (cmd_i.cap_az) begin
      ca_q <= cord_cos;
      sa_q <= cord_sin;
    end
    if (cmd_i.cap_el) begin
      ce_q <= cord_cos;
      se_q <= cord_sin;
    end
    if (cmd_i.cap_ph) begin
      cv_q <= cord_cos;
      sv_q <= cord_sin;
    end
    if (cmd_i.dir0) dir0_q <= 32'((64'(ce_q) * 64'(ca_q)) >>> 30);
    if (cmd_i.dir1) dir1_q <= 32'((64'(ce_q) * 64'(sa_q)) >>> 30);
    if (cmd_i.ev_init) begin
      big_q <= '0;
      sh_q  <= '0;
      num_q <= '0;
      den_q <= '0;
    end
    if (cmd_i.max_step && (int'(hi_q) < int'(used))) begin
      if (abs_re > big_q && abs_re >= abs_im) big_q <= abs_re;
      else if (abs_im > big_q) big_q <= abs_im;
    end
    if (cmd_i.sh_step) sh_q <= sh_q + SH_W'(1);
    if (cmd_i.ev_load) begin
      re_q  <= sh_re[31:0];
      im_q  <= sh_im[31:0];
      dot_q <= '0;
      dim_q <= '0;
    end
    if (cmd_i.dot_step) begin
      dot_q <= dot_q + DOT_W'(dprod);
      dim_q <= dim_q + DIM_W'(1);
    end
    if (cmd_i.phase) phase_q <= ph_prod[31:0];
    if (cmd_i.n0) t0_q <= 64'(re_q) * 64'(cv_q);
    if (cmd_i.n1) t1_q <= 64'(im_q) * 64'(sv_q);
    if (cmd_i.n2) num_q <= num_q + NUM_W'(tsh);
    if (cmd_i.m0) m0_q <= 64'(re_q) * 64'(re_q);
    if (cmd_i.m1) m1_q <= 64'(im_q) * 64'(im_q);
    if (cmd_i.sq_load) begin
      sq_v_q    <= m0_q + m1_q;
      sq_root_q <= '0;
      sq_bit_q  <= 64'h4000_0000_0000_0000;
    end else if (cmd_i.sq_step) begin
      if (sq_v_q >= sq_trial) begin
        sq_v_q    <= sq_v_q - sq_trial;
        sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
      end else begin
        sq_root_q <= sq_root_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
    if (cmd_i.den_add) den_q <= den_q + DEN_W'(sq_root_q[31:0]);
    if (cmd_i.div_load) begin
      nq_q      <= (DIVN_W'(num_abs) << 14) + DIVN_W'(den_q >> 1);
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DIVC_W'(1);
      if (div_trial >= {1'b0, den_q}) begin
        rem_q <= DEN_W'(div_trial - {1'b0, den_q});
        nq_q  <= {nq_q[DIVN_W-2:0], 1'b1};
      end else begin
        rem_q <= div_trial[DEN_W-1:0];
        nq_q  <= {nq_q[DIVN_W-2:0], 1'b0};
      end
    end
    if (cmd_i.res_write) begin
      if (den_q == '0) begin
        out_q.likelihood <= '0;
        out_q.no_signal  <= 1'b1;
      end else begin
        out_q.likelihood <= num_pos ? $signed(-q_mag) : $signed(q_mag);
        out_q.no_signal  <= 1'b0;
      end
    end
  end

  // ---------------- status ----------------
  always_comb begin
    stat_o.cmd       = cmd_e'(item_q.cmd);
    stat_o.commit_go = ch_ok && (int'(used) >= 2) && (int'(item_q.channel) == int'(used) - 1);
    stat_o.in_window = (idx_q >= first_q) && (idx_q <= last_q);
    stat_o.pair_used = int'(hi_q) < int'(used);
    stat_o.pair_last = pair_last;
    stat_o.cord_done = cord_done;
    stat_o.sh_done   = (big_sh >> 31) == '0;
    stat_o.dot_done  = dim_q == DIM_W'(DIMENSIONS - 1);
    stat_o.sq_done   = sq_bit_q == 64'd1;
    stat_o.den_zero  = den_q == '0;
    stat_o.div_done  = div_cnt_q == DIVC_W'(DIVN_W - 1);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/idl_ctrl.sv
// ----------------------------------------------------------------------------
// idl_ctrl
// Sequencer: decodes an item and steps the datapath through clear, load, commit or evaluate.
// ----------------------------------------------------------------------------
module idl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  idl_pkg::idl_stat_t stat_i,
  output idl_pkg::idl_cmd_t  cmd_o
);
  import idl_pkg::*;

  typedef enum logic [28:0] {
    S_IDLE    = 29'(1) << 0,
    S_DECODE  = 29'(1) << 1,
    S_CM_RD   = 29'(1) << 2,
    S_CM_MUL  = 29'(1) << 3,
    S_CM_ACC  = 29'(1) << 4,
    S_CM_END  = 29'(1) << 5,
    S_EV_CA   = 29'(1) << 6,
    S_EV_CAW  = 29'(1) << 7,
    S_EV_CEW  = 29'(1) << 8,
    S_EV_DIR0 = 29'(1) << 9,
    S_EV_DIR1 = 29'(1) << 10,
    S_EV_MAX  = 29'(1) << 11,
    S_EV_SH   = 29'(1) << 12,
    S_EV_RD   = 29'(1) << 13,
    S_EV_DOT  = 29'(1) << 14,
    S_EV_PH   = 29'(1) << 15,
    S_EV_CS   = 29'(1) << 16,
    S_EV_CW   = 29'(1) << 17,
    S_EV_N0   = 29'(1) << 18,
    S_EV_N1   = 29'(1) << 19,
    S_EV_N2   = 29'(1) << 20,
    S_EV_M0   = 29'(1) << 21,
    S_EV_M1   = 29'(1) << 22,
    S_EV_SQ0  = 29'(1) << 23,
    S_EV_SQ   = 29'(1) << 24,
    S_EV_DEN  = 29'(1) << 25,
    S_EV_DIV0 = 29'(1) << 26,
    S_EV_DIV  = 29'(1) << 27,
    S_EV_OUT  = 29'(1) << 28
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.cmd)
          CMD_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d = S_IDLE;
          end
          CMD_LOAD_POS: begin
            cmd_o.pos_wr = 1'b1;
            state_d = S_IDLE;
          end
          CMD_LOAD_SMP: begin
            cmd_o.smp_wr = 1'b1;
            if (!stat_i.commit_go) begin
              state_d = S_IDLE;
            end else if (stat_i.in_window) begin
              cmd_o.pair_rst = 1'b1;
              state_d = S_CM_RD;
            end else begin
              state_d = S_CM_END;
            end
          end
          CMD_EVALUATE: begin
            cmd_o.ev_init = 1'b1;
            state_d = S_EV_CA;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_CM_RD: begin
        if (stat_i.pair_used) begin
          state_d = S_CM_MUL;
        end else if (stat_i.pair_last) begin
          state_d = S_CM_END;
        end else begin
          cmd_o.pair_next = 1'b1;
        end
      end
      S_CM_MUL: begin
        cmd_o.cm_mul = 1'b1;
        state_d = S_CM_ACC;
      end
      S_CM_ACC: begin
        cmd_o.cm_acc = 1'b1;
        if (stat_i.pair_last) begin
          state_d = S_CM_END;
        end else begin
          cmd_o.pair_next = 1'b1;
          state_d = S_CM_RD;
        end
      end
      S_CM_END: begin
        cmd_o.idx_bump = 1'b1;
        state_d = S_IDLE;
      end
      S_EV_CA: begin
        cmd_o.cord_az = 1'b1;
        state_d = S_EV_CAW;
      end
      S_EV_CAW: begin
        if (stat_i.cord_done) begin
          cmd_o.cap_az  = 1'b1;
          cmd_o.cord_el = 1'b1;
          state_d = S_EV_CEW;
        end
      end
      S_EV_CEW: begin
        if (stat_i.cord_done) begin
          cmd_o.cap_el = 1'b1;
          state_d = S_EV_DIR0;
        end
      end
      S_EV_DIR0: begin
        cmd_o.dir0 = 1'b1;
        state_d = S_EV_DIR1;
      end
      S_EV_DIR1: begin
        cmd_o.dir1     = 1'b1;
        cmd_o.pair_rst = 1'b1;
        state_d = S_EV_MAX;
      end
      S_EV_MAX: begin
        cmd_o.max_step = 1'b1;
        if (stat_i.pair_last) begin
          cmd_o.pair_rst = 1'b1;
          state_d = S_EV_SH;
        end else begin
          cmd_o.pair_next = 1'b1;
        end
      end
      S_EV_SH: begin
        if (stat_i.sh_done) begin
          state_d = S_EV_RD;
        end else begin
          cmd_o.sh_step = 1'b1;
        end
      end
      S_EV_RD: begin
        if (stat_i.pair_used) begin
          cmd_o.ev_load = 1'b1;
          state_d = S_EV_DOT;
        end else if (stat_i.pair_last) begin
          state_d = S_EV_DIV0;
        end else begin
          cmd_o.pair_next = 1'b1;
        end
      end
      S_EV_DOT: begin
        cmd_o.dot_step = 1'b1;
        if (stat_i.dot_done) state_d = S_EV_PH;
      end
      S_EV_PH: begin
        cmd_o.phase = 1'b1;
        state_d = S_EV_CS;
      end
      S_EV_CS: begin
        cmd_o.cord_ph = 1'b1;
        state_d = S_EV_CW;
      end
      S_EV_CW: begin
        if (stat_i.cord_done) begin
          cmd_o.cap_ph = 1'b1;
          state_d = S_EV_N0;
        end
      end
      S_EV_N0: begin
        cmd_o.n0 = 1'b1;
        state_d = S_EV_N1;
      end
      S_EV_N1: begin
        cmd_o.n1 = 1'b1;
        state_d = S_EV_N2;
      end
      S_EV_N2: begin
        cmd_o.n2 = 1'b1;
        state_d = S_EV_M0;
      end
      S_EV_M0: begin
        cmd_o.m0 = 1'b1;
        state_d = S_EV_M1;
      end
      S_EV_M1: begin
        cmd_o.m1 = 1'b1;
        state_d = S_EV_SQ0;
      end
      S_EV_SQ0: begin
        cmd_o.sq_load = 1'b1;
        state_d = S_EV_SQ;
      end
      S_EV_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (stat_i.sq_done) state_d = S_EV_DEN;
      end
      S_EV_DEN: begin
        cmd_o.den_add = 1'b1;
        if (stat_i.pair_last) begin
          state_d = S_EV_DIV0;
        end else begin
          cmd_o.pair_next = 1'b1;
          state_d = S_EV_RD;
        end
      end
      S_EV_DIV0: begin
        if (stat_i.den_zero) begin
          state_d = S_EV_OUT;
        end else begin
          cmd_o.div_load = 1'b1;
          state_d = S_EV_DIV;
        end
      end
      S_EV_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = S_EV_OUT;
      end
      S_EV_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.res_write = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

FILE: hdl/interferometer_doa_likelihood.sv
// ----------------------------------------------------------------------------
// interferometer_doa_likelihood
// Correlative interferometer direction-finding likelihood engine.
//
//  channel   signals                               width
//  input     in_valid_i / in_ready_o / in_item_i   in_item_t
//  output    out_valid_o / out_ready_i / out_item_o out_item_t
//  config    cfg_we_i / cfg_addr_i / cfg_wdata_i    2 + 32
//
// One item at a time. Clear, position load and a plain sample load go back to idle;
// a snapshot end outside the window only bumps the index, else it also walks the pairs.
// An evaluate walks the pairs and uses the shared CORDIC, square root and divider,
// skipping the divider with no signal.
// Reset is asynchronous and clears sums and index. A finished result waits in the
// output register; the next item is still taken, and an evaluate holds until it is free.
// ----------------------------------------------------------------------------
module interferometer_doa_likelihood (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  idl_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output idl_pkg::out_item_t  out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [31:0]         cfg_wdata_i
);
  import idl_pkg::*;

  idl_cmd_t  cmd;
  idl_stat_t stat;

  idl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .stat_i(stat), .cmd_o(cmd));

  idl_datapath u_dp (
    .clk_i, .rst_ni, .in_item_i, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .out_ready_i, .out_item_o, .out_valid_o,
    .cmd_i(cmd), .stat_o(stat));

endmodule

FILE: tb/sv/tb_interferometer_doa_likelihood.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interferometer_doa_likelihood
// Self-checking bench: a clocked driver feeds queued command items, a bit-exact
// predictor tracks positions, samples and pair sums, and a monitor checks each
// likelihood result in order under several configurations and idle patterns.
// ----------------------------------------------------------------------------
module tb_interferometer_doa_likelihood;
  import idl_pkg::*;

  localparam int    NCH       = MAX_CHANNELS;
  localparam int    CYC_LIMIT = 10000000;
  localparam int    SETTLE    = 400;
  localparam int    ITEM_W    = $bits(in_item_t);
  localparam longint SUM_HI   = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_LO   = -SUM_HI - 1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  interferometer_doa_likelihood u_dut (.*);

  // predictor state
  int unsigned  act_ch = 8, win_first = 0, win_last = 65535;
  logic [31:0]  wave_num = 32'd65536;
  longint       elem_pos [NCH][3];
  longint       snap_smp [NCH][2];
  longint       corr_re [PAIRS];
  longint       corr_im [PAIRS];
  int unsigned  snap_idx = 0;
  longint       atan_tab [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                  21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                                  333772, 166886, 83443, 41722, 20861};

  in_item_t  pending_items[$];
  out_item_t expected_lh[$];
  int        send_idle_pct = 0, recv_stall_pct = 0;
  int        errors = 0;
  int        cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned used_ch();
    return (act_ch > NCH) ? NCH : act_ch;
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    int     ai;
    logic   flip;
    x = CORDIC_K_Q30;
    y = 0;
    flip = ang[31] ^ ang[30];      // outside +-quarter turn
    if (flip) ang = ang + 32'h8000_0000;
    ai = ang;
    z = ai;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[k];
      end else begin
        x += dx; y -= dy; z += atan_tab[k];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint sat_sum(longint acc, longint add);
    longint r;
    r = acc + add;
    if (r > SUM_HI) return SUM_HI;
    if (r < SUM_LO) return SUM_LO;
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic accumulate_snapshot(input int unsigned used);
    int p;
    p = 0;
    if (snap_idx >= win_first && snap_idx <= win_last) begin
      for (int lo = 0; lo < NCH; lo++)
        for (int hi = lo + 1; hi < NCH; hi++, p++) begin
          if (hi >= used) continue;
          corr_re[p] = sat_sum(corr_re[p], snap_smp[hi][0] * snap_smp[lo][0]
                                         + snap_smp[hi][1] * snap_smp[lo][1]);
          corr_im[p] = sat_sum(corr_im[p], snap_smp[hi][1] * snap_smp[lo][0]
                                         - snap_smp[hi][0] * snap_smp[lo][1]);
        end
    end
    if (snap_idx < 65535) snap_idx++;
  endtask

  task automatic likelihood_at(input logic [15:0] az, input logic [15:0] el,
                               output out_item_t res);
    longint          ca, sa, ce, se, cv, sv, re, im, dotp, num, den, qs;
    longint          dir [3];
    longint unsigned biggest, q;
    logic [31:0]     phase;
    int unsigned     used;
    int              sh, p;
    used = used_ch();
    num = 0; den = 0; biggest = 0; sh = 0;
    rotate({az, 16'h0}, ca, sa);
    rotate({el, 16'h0}, ce, se);
    dir[0] = (ce * ca) >>> 30;
    dir[1] = (ce * sa) >>> 30;
    dir[2] = se;
    p = 0;
    for (int lo = 0; lo < NCH; lo++)
      for (int hi = lo + 1; hi < NCH; hi++, p++) begin
        if (hi >= used) continue;
        if (mag(corr_re[p]) > biggest) biggest = mag(corr_re[p]);
        if (mag(corr_im[p]) > biggest) biggest = mag(corr_im[p]);
      end
    while (sh < 63 && (biggest >> sh) >= 64'h8000_0000) sh++;
    p = 0;
    for (int lo = 0; lo < NCH; lo++)
      for (int hi = lo + 1; hi < NCH; hi++, p++) begin
        if (hi >= used) continue;
        re = corr_re[p] >>> sh;
        im = corr_im[p] >>> sh;
        den += floor_sqrt(re * re + im * im);
        dotp = 0;
        for (int k = 0; k < 3; k++) dotp += (elem_pos[hi][k] - elem_pos[lo][k]) * dir[k];
        dotp = dotp >>> 24;
        phase = 32'(longint'({32'h0, wave_num}) * dotp);
        rotate(phase, cv, sv);
        num += (re * cv + im * sv) >>> 30;
      end
    res = '0;
    if (den == 0) begin
      res.no_signal = 1'b1;
    end else begin
      q = (mag(num) * 16384 + den / 2) / den;
      if (q > 16384) q = 16384;
      qs = q;
      res.likelihood = 16'((num > 0) ? -qs : qs);
    end
  endtask

  task automatic predict(input in_item_t it);
    out_item_t   r;
    int unsigned used;
    used = used_ch();
    case (cmd_e'(it.cmd))
      CMD_CLEAR: begin
        for (int p = 0; p < PAIRS; p++) begin
          corr_re[p] = 0; corr_im[p] = 0;
        end
        snap_idx = 0;
      end
      CMD_LOAD_POS: begin
        elem_pos[it.channel][0] = it.pos_x;
        elem_pos[it.channel][1] = it.pos_y;
        elem_pos[it.channel][2] = it.pos_z;
      end
      CMD_LOAD_SMP: begin
        snap_smp[it.channel][0] = it.samp_re;
        snap_smp[it.channel][1] = it.samp_im;
        if (used >= 2 && it.channel == used - 1) accumulate_snapshot(used);
      end
      default: begin
        likelihood_at(it.azimuth, it.elevation, r);
        expected_lh.insert(expected_lh.size(), r);
      end
    endcase
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) predict(in_item_i);
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_item_i  <= pending_items.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_lh.size() == 0) begin
        $display("%0t: unexpected result lh=%0d no_signal=%0b", $time,
                 out_item_o.likelihood, out_item_o.no_signal);
        errors++;
      end else begin
        out_item_t e;
        e = expected_lh.pop_front();
        if (e.likelihood !== out_item_o.likelihood) begin
          $display("%0t: likelihood expected %0d actual %0d", $time,
                   e.likelihood, out_item_o.likelihood);
          errors++;
        end
        if (e.no_signal !== out_item_o.no_signal) begin
          $display("%0t: no_signal expected %0b actual %0b", $time,
                   e.no_signal, out_item_o.no_signal);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input cfg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ACTIVE_CHANNELS: act_ch = val[3:0];
      CFG_WINDOW_FIRST:    win_first = val[15:0];
      CFG_WINDOW_LAST:     win_last = val[15:0];
      default:             wave_num = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_lh.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rnd_item();
    return in_item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom}));
  endfunction

  task automatic add_item(input in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_pos(input int ch, input logic [15:0] x, y, z);
    in_item_t it;
    it = rnd_item();
    it.cmd = CMD_LOAD_POS; it.channel = 3'(ch);
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    add_item(it);
  endtask

  task automatic add_smp(input int ch, input logic [15:0] re, im);
    in_item_t it;
    it = rnd_item();
    it.cmd = CMD_LOAD_SMP; it.channel = 3'(ch);
    it.samp_re = re; it.samp_im = im;
    add_item(it);
  endtask

  task automatic add_eval(input logic [15:0] az, el);
    in_item_t it;
    it = rnd_item();
    it.cmd = CMD_EVALUATE; it.azimuth = az; it.elevation = el;
    add_item(it);
  endtask

  task automatic add_clear();
    in_item_t it;
    it = rnd_item();
    it.cmd = CMD_CLEAR;
    add_item(it);
  endtask

  // mostly full snapshots followed by evaluates, with some noise
  task automatic random_items(input int n);
    int cnt, r;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 45) begin
        for (int ch = 0; ch < used_ch(); ch++) add_smp(ch, rnd16(), rnd16());
        cnt += used_ch();
      end else if (r < 70) begin
        add_eval(16'($urandom), ($urandom_range(9) == 0) ? 16'($urandom)
                                : 16'($urandom_range(32768) - 16384));
        cnt++;
      end else if (r < 80) begin
        add_pos($urandom_range(NCH - 1), rnd16(), rnd16(), rnd16());
        cnt++;
      end else if (r < 85) begin
        add_clear();
        cnt++;
      end else begin
        add_smp($urandom_range(NCH - 1), rnd16(), rnd16());
        cnt++;
      end
    end
  endtask

  task automatic set_idle(input int snd, input int rcv);
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
  endtask

  initial begin
    for (int p = 0; p < PAIRS; p++) begin
      corr_re[p] = 0; corr_im[p] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: every entry written before anything reads it
    set_idle(0, 0);
    add_pos(0, 16'h8000, 16'h7FFF, 16'h0000);
    add_pos(1, 16'h7FFF, 16'h8000, 16'hFFFF);
    for (int ch = 2; ch < NCH; ch++) add_pos(ch, rnd16(), rnd16(), rnd16());
    add_smp(0, 16'h8000, 16'h8000);
    add_smp(1, 16'h7FFF, 16'h8000);
    for (int ch = 2; ch < NCH; ch++) add_smp(ch, rnd16(), rnd16());
    add_eval(16'h0000, 16'h0000);
    add_eval(16'hFFFF, 16'hC000);   // down quarter turn
    add_eval(16'h4000, 16'h4000);   // up quarter turn
    add_eval(16'h8000, 16'h7FFF);   // elevation past a quarter turn
    add_eval(16'hC000, 16'h8000);
    add_clear();
    add_eval(16'h1234, 16'h0100);   // cleared sums: no signal
    drain();

    write_reg(CFG_ACTIVE_CHANNELS, 32'd8);
    write_reg(CFG_WINDOW_FIRST, 32'd0);
    write_reg(CFG_WINDOW_LAST, 32'd65535);
    write_reg(CFG_WAVE_NUMBER, 32'd65536);
    random_items(160);
    drain();

    set_idle(83, 0);
    write_reg(CFG_ACTIVE_CHANNELS, 32'd2);
    write_reg(CFG_WINDOW_FIRST, 32'd3);
    write_reg(CFG_WINDOW_LAST, 32'd10);
    write_reg(CFG_WAVE_NUMBER, 32'd0);
    add_clear();
    random_items(150);
    drain();

    set_idle(0, 83);
    write_reg(CFG_ACTIVE_CHANNELS, 32'd5);
    write_reg(CFG_WINDOW_FIRST, 32'd0);
    write_reg(CFG_WINDOW_LAST, 32'd0);
    write_reg(CFG_WAVE_NUMBER, 32'hFFFF_FFFF);
    add_clear();
    random_items(150);
    drain();

    // empty window, count above the channel maximum
    set_idle(22, 22);
    write_reg(CFG_ACTIVE_CHANNELS, 32'd15);
    write_reg(CFG_WINDOW_FIRST, 32'd20);
    write_reg(CFG_WINDOW_LAST, 32'd5);
    write_reg(CFG_WAVE_NUMBER, $urandom);
    random_items(120);
    drain();

    // fewer than two channels: no pairs
    set_idle(0, 0);
    write_reg(CFG_ACTIVE_CHANNELS, $urandom_range(1));
    write_reg(CFG_WINDOW_FIRST, 32'd0);
    write_reg(CFG_WINDOW_LAST, 32'd65535);
    random_items(60);
    drain();

    set_idle(22, 22);
    write_reg(CFG_ACTIVE_CHANNELS, 32'd8);
    write_reg(CFG_WAVE_NUMBER, 32'($urandom_range(1 << 20)));
    random_items(170);
    drain();

    set_idle(0, 83);
    write_reg(CFG_ACTIVE_CHANNELS, 32'd3);
    write_reg(CFG_WINDOW_FIRST, 32'd65535);
    write_reg(CFG_WINDOW_LAST, 32'd65535);
    write_reg(CFG_WAVE_NUMBER, $urandom);
    random_items(120);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/idl_pkg.sv
hdl/idl_ram.sv
hdl/idl_cordic.sv
hdl/idl_datapath.sv
hdl/idl_ctrl.sv
hdl/interferometer_doa_likelihood.sv
tb/sv/tb_interferometer_doa_likelihood.sv
